/* rtl/gbi_pkg.sv */
// shared types and constants for the gpio bank with pin interrupts
package gbi_pkg;

  localparam int PIN_W  = 32;
  localparam int IDX_W  = 6;
  localparam int CMD_W  = 2;
  localparam int PEND_W = 5;
  localparam int IN_W   = 72;
  localparam int OUT_W  = 232;

  // commands carried in s_tuser
  localparam logic [CMD_W-1:0] CMD_READ  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_WRITE = 2'd1;

  // register offsets, byte offset divided by four
  localparam logic [IDX_W-1:0] IDX_PINS      = 6'd0;
  localparam logic [IDX_W-1:0] IDX_DATA      = 6'd4;
  localparam logic [IDX_W-1:0] IDX_DATA_SET  = 6'd5;
  localparam logic [IDX_W-1:0] IDX_DATA_CLR  = 6'd6;
  localparam logic [IDX_W-1:0] IDX_MASK      = 6'd8;
  localparam logic [IDX_W-1:0] IDX_MASK_SET  = 6'd9;
  localparam logic [IDX_W-1:0] IDX_MASK_CLR  = 6'd10;
  localparam logic [IDX_W-1:0] IDX_PULL      = 6'd12;
  localparam logic [IDX_W-1:0] IDX_PULL_SET  = 6'd13;
  localparam logic [IDX_W-1:0] IDX_PULL_CLR  = 6'd14;
  localparam logic [IDX_W-1:0] IDX_FUNC      = 6'd16;
  localparam logic [IDX_W-1:0] IDX_FUNC_SET  = 6'd17;
  localparam logic [IDX_W-1:0] IDX_FUNC_CLR  = 6'd18;
  localparam logic [IDX_W-1:0] IDX_SEL       = 6'd20;
  localparam logic [IDX_W-1:0] IDX_SEL_SET   = 6'd21;
  localparam logic [IDX_W-1:0] IDX_SEL_CLR   = 6'd22;
  localparam logic [IDX_W-1:0] IDX_DIR       = 6'd24;
  localparam logic [IDX_W-1:0] IDX_DIR_SET   = 6'd25;
  localparam logic [IDX_W-1:0] IDX_DIR_CLR   = 6'd26;
  localparam logic [IDX_W-1:0] IDX_TRIG      = 6'd28;
  localparam logic [IDX_W-1:0] IDX_TRIG_SET  = 6'd29;
  localparam logic [IDX_W-1:0] IDX_TRIG_CLR  = 6'd30;
  localparam logic [IDX_W-1:0] IDX_FLAG      = 6'd32;

  typedef struct packed {
    logic data_set;
    logic data_clr;
    logic mask_set;
    logic mask_clr;
    logic pull_set;
    logic pull_clr;
    logic func_set;
    logic func_clr;
    logic sel_set;
    logic sel_clr;
    logic dir_set;
    logic dir_clr;
    logic trig_set;
    logic trig_clr;
  } write_strobe_t;

  // register bits of one pin
  typedef struct packed {
    logic data;
    logic mask;
    logic pull;
    logic func;
    logic sel;
    logic dir;
    logic trig;
    logic flag;
  } lane_bits_t;

  // the same registers gathered across the bank
  typedef struct packed {
    logic [PIN_W-1:0] data;
    logic [PIN_W-1:0] mask;
    logic [PIN_W-1:0] pull;
    logic [PIN_W-1:0] func;
    logic [PIN_W-1:0] sel;
    logic [PIN_W-1:0] dir;
    logic [PIN_W-1:0] trig;
    logic [PIN_W-1:0] flag;
  } bank_words_t;

  // result word, last field in the lowest bits
  typedef struct packed {
    logic              pad;
    logic [PEND_W-1:0] pending_pin;
    logic              pending_valid;
    logic              irq_line;
    logic [PIN_W-1:0]  alt_high;
    logic [PIN_W-1:0]  alt_select;
    logic [PIN_W-1:0]  func_select;
    logic [PIN_W-1:0]  pull_disabled;
    logic [PIN_W-1:0]  pin_drive_enable;
    logic [PIN_W-1:0]  pin_out;
    logic [PIN_W-1:0]  read_data;
  } result_t;

endpackage

/* rtl/gbi_lane.sv */
// one pin lane: its register bits, alias writes and interrupt detection
module gbi_lane (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   en,
  input  gbi_pkg::write_strobe_t wr,
  input  logic                   wd,
  input  logic                   pin,
  output gbi_pkg::lane_bits_t    cur,
  output gbi_pkg::lane_bits_t    nxt
);
  import gbi_pkg::*;

  // reset value: everything clear except the mask bit
  localparam lane_bits_t LANE_RESET = '{1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0};

  lane_bits_t regs;
  logic       prev;
  logic       imode_old;
  logic       imode_new;
  logic       edge_hit;
  logic       level_hit;
  logic       hit;

  assign cur = regs;

  always_comb begin
    imode_old = ~regs.func & regs.sel;
    nxt = regs;
    // data set alias acks flags of interrupt pins, sets data elsewhere
    if (wr.data_set) begin
      nxt.flag = regs.flag & ~(wd & imode_old);
      nxt.data = regs.data | (wd & ~imode_old);
    end
    if (wr.data_clr) nxt.data = regs.data & ~wd;
    if (wr.mask_set) nxt.mask = regs.mask | wd;
    if (wr.mask_clr) nxt.mask = regs.mask & ~wd;
    if (wr.pull_set) nxt.pull = regs.pull | wd;
    if (wr.pull_clr) nxt.pull = regs.pull & ~wd;
    if (wr.func_set) nxt.func = regs.func | wd;
    if (wr.func_clr) nxt.func = regs.func & ~wd;
    if (wr.sel_set)  nxt.sel  = regs.sel | wd;
    if (wr.sel_clr)  nxt.sel  = regs.sel & ~wd;
    if (wr.dir_set)  nxt.dir  = regs.dir | wd;
    if (wr.dir_clr)  nxt.dir  = regs.dir & ~wd;
    if (wr.trig_set) nxt.trig = regs.trig | wd;
    if (wr.trig_clr) nxt.trig = regs.trig & ~wd;
    // detection with the updated configuration
    imode_new = ~nxt.func & nxt.sel;
    edge_hit  = nxt.dir ? (pin & ~prev) : (~pin & prev);
    level_hit = ~(pin ^ nxt.dir);
    hit       = imode_new & (nxt.trig ? edge_hit : level_hit);
    nxt.flag  = nxt.flag | hit;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      regs <= LANE_RESET;
      prev <= 1'b0;
    end else if (en) begin
      regs <= nxt;
      prev <= pin;
    end
  end

endmodule

/* rtl/gbi_merge.sv */
// merge of lane results: read mux, interrupt line and lowest pending pin
module gbi_merge (
  input  logic                          is_read,
  input  logic [gbi_pkg::IDX_W-1:0]     reg_index,
  input  logic [gbi_pkg::PIN_W-1:0]     pins,
  input  gbi_pkg::bank_words_t          old_w,
  input  gbi_pkg::bank_words_t          new_w,
  output gbi_pkg::result_t              res
);
  import gbi_pkg::*;

  logic [PIN_W-1:0]  rd;
  logic [PIN_W-1:0]  lowest;
  logic [PEND_W-1:0] enc;

  always_comb begin
    rd = '0;
    if (is_read) begin
      unique case (reg_index)
        IDX_PINS: rd = pins;
        IDX_DATA: rd = old_w.data;
        IDX_MASK: rd = old_w.mask;
        IDX_PULL: rd = old_w.pull;
        IDX_FUNC: rd = old_w.func;
        IDX_SEL:  rd = old_w.sel;
        IDX_DIR:  rd = old_w.dir;
        IDX_TRIG: rd = old_w.trig;
        IDX_FLAG: rd = old_w.flag;
        default:  rd = '0;
      endcase
    end
  end

  // isolate lowest set flag, then encode the one-hot word
  assign lowest = new_w.flag & (~new_w.flag + PIN_W'(1));

  always_comb begin
    enc = '0;
    for (int j = 0; j < PIN_W; j++) begin
      if (lowest[j]) enc = enc | PEND_W'(j);
    end
  end

  always_comb begin
    res                  = '0;
    res.read_data        = rd;
    res.pin_out          = new_w.data;
    res.pin_drive_enable = new_w.dir & ~new_w.func & ~new_w.sel;
    res.pull_disabled    = new_w.pull;
    res.func_select      = new_w.func;
    res.alt_select       = new_w.sel;
    res.alt_high         = new_w.trig;
    res.irq_line         = |(new_w.flag & ~new_w.mask);
    res.pending_valid    = |new_w.flag;
    res.pending_pin      = enc;
  end

endmodule

/* rtl/gpio_bank_with_pin_interrupts.sv */
// top level of the gpio bank: pin lanes, merge stage and output buffer
//
// One bank of up to 32 gpio pins with per-pin interrupts. Each input word is a
// bus read, a bus write (to a set or clear alias) or an idle tick, and always
// carries the sampled pin levels. The block takes one word per clock while the
// skid entry is empty and hands back one result word per input word, in order,
// registered on acceptance. Every pin has its own lane holding its register
// bits; all lanes update in the same cycle, so the next word sees the new state
// with no gap. A merge stage builds the read word, the interrupt line and the
// lowest pending pin. Results go to an output register backed by one skid entry,
// so s_tready depends only on whether the skid entry is full; with m_tready held
// high the block runs at one word per cycle indefinitely.
module gpio_bank_with_pin_interrupts #(
  parameter int NUM_PINS = 32
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        s_tvalid,
  output logic                        s_tready,
  // reg_index [5:0], write_data [37:6], pin_levels [69:38], zero pad [71:70]
  input  logic [gbi_pkg::IN_W-1:0]    s_tdata,
  // command [1:0]
  input  logic [gbi_pkg::CMD_W-1:0]   s_tuser,
  output logic                        m_tvalid,
  input  logic                        m_tready,
  // read_data [31:0], pin_out [63:32], pin_drive_enable [95:64],
  // pull_disabled [127:96], func_select [159:128], alt_select [191:160],
  // alt_high [223:192], irq_line [224], pending_valid [225],
  // pending_pin [230:226], zero pad [231]
  output logic [gbi_pkg::OUT_W-1:0]   m_tdata
);
  import gbi_pkg::*;

  localparam logic [PIN_W-1:0] PIN_MASK = {PIN_W{1'b1}} >> (PIN_W - NUM_PINS);

  logic [IDX_W-1:0] reg_index;
  logic [PIN_W-1:0] write_data;
  logic [PIN_W-1:0] pins;
  logic             accept;
  write_strobe_t    wr;
  lane_bits_t       cur_a [PIN_W];
  lane_bits_t       nxt_a [PIN_W];
  bank_words_t      old_w;
  bank_words_t      new_w;
  result_t          res;
  result_t          skid;
  logic             skid_valid;
  logic             take;

  assign reg_index  = s_tdata[IDX_W-1:0];
  assign write_data = s_tdata[IDX_W +: PIN_W] & PIN_MASK;
  assign pins       = s_tdata[IDX_W+PIN_W +: PIN_W] & PIN_MASK;
  assign accept     = s_tvalid && s_tready;

  // alias decode, only on an accepted write
  always_comb begin
    wr = '0;
    if (accept && s_tuser == CMD_WRITE) begin
      unique case (reg_index)
        IDX_DATA_SET: wr.data_set = 1'b1;
        IDX_DATA_CLR: wr.data_clr = 1'b1;
        IDX_MASK_SET: wr.mask_set = 1'b1;
        IDX_MASK_CLR: wr.mask_clr = 1'b1;
        IDX_PULL_SET: wr.pull_set = 1'b1;
        IDX_PULL_CLR: wr.pull_clr = 1'b1;
        IDX_FUNC_SET: wr.func_set = 1'b1;
        IDX_FUNC_CLR: wr.func_clr = 1'b1;
        IDX_SEL_SET:  wr.sel_set  = 1'b1;
        IDX_SEL_CLR:  wr.sel_clr  = 1'b1;
        IDX_DIR_SET:  wr.dir_set  = 1'b1;
        IDX_DIR_CLR:  wr.dir_clr  = 1'b1;
        IDX_TRIG_SET: wr.trig_set = 1'b1;
        IDX_TRIG_CLR: wr.trig_clr = 1'b1;
        default:      wr = '0;
      endcase
    end
  end

  // one lane per implemented pin, missing pins read as zero
  for (genvar i = 0; i < PIN_W; i++) begin : g_lane
    if (i < NUM_PINS) begin : g_pin
      gbi_lane u_lane (
        .clk (clk),
        .rst (rst),
        .en  (accept),
        .wr  (wr),
        .wd  (write_data[i]),
        .pin (pins[i]),
        .cur (cur_a[i]),
        .nxt (nxt_a[i])
      );
    end else begin : g_none
      assign cur_a[i] = '0;
      assign nxt_a[i] = '0;
    end
  end

  // gather lane bits into bank words
  always_comb begin
    for (int j = 0; j < PIN_W; j++) begin
      old_w.data[j] = cur_a[j].data;
      old_w.mask[j] = cur_a[j].mask;
      old_w.pull[j] = cur_a[j].pull;
      old_w.func[j] = cur_a[j].func;
      old_w.sel[j]  = cur_a[j].sel;
      old_w.dir[j]  = cur_a[j].dir;
      old_w.trig[j] = cur_a[j].trig;
      old_w.flag[j] = cur_a[j].flag;
      new_w.data[j] = nxt_a[j].data;
      new_w.mask[j] = nxt_a[j].mask;
      new_w.pull[j] = nxt_a[j].pull;
      new_w.func[j] = nxt_a[j].func;
      new_w.sel[j]  = nxt_a[j].sel;
      new_w.dir[j]  = nxt_a[j].dir;
      new_w.trig[j] = nxt_a[j].trig;
      new_w.flag[j] = nxt_a[j].flag;
    end
  end

  gbi_merge u_merge (
    .is_read   (s_tuser == CMD_READ),
    .reg_index (reg_index),
    .pins      (pins),
    .old_w     (old_w),
    .new_w     (new_w),
    .res       (res)
  );

  // output register plus one skid entry
  assign s_tready = !skid_valid;
  assign take     = m_tvalid && m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid   <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (take) begin
        m_tdata    <= skid;
        skid_valid <= 1'b0;
      end
    end else if (accept) begin
      if (!m_tvalid || take) begin
        m_tdata  <= res;
        m_tvalid <= 1'b1;
      end else begin
        skid       <= res;
        skid_valid <= 1'b1;
      end
    end else if (take) begin
      m_tvalid <= 1'b0;
    end
  end

endmodule

/* tb/gpio_bank_with_pin_interrupts_test.sv */
// self-checking testbench for the gpio bank with pin interrupts
`timescale 1ns / 1ps

module gpio_bank_with_pin_interrupts_test;
  import gbi_pkg::*;

  // idle ticks, the package names only read and write
  localparam logic [CMD_W-1:0] CMD_IDLE     = 2'd2;
  localparam logic [CMD_W-1:0] CMD_IDLE_ALT = 2'd3;
  // highest offset, never mapped
  localparam logic [IDX_W-1:0] IDX_TOP      = 6'd63;

  localparam int RANDOM_WORDS   = 1525;
  localparam int WATCHDOG_LIMIT = 1000;
  localparam int DRAIN_CYCLES   = 16;
  localparam int PRINT_CAP      = 30;
  localparam int DIRECTED_ROWS  = 27;

  logic                clk;
  logic                rst = 1'b1;
  logic                s_tvalid = 1'b0;
  logic                s_tready;
  logic [IN_W-1:0]     s_tdata = '0;
  logic [CMD_W-1:0]    s_tuser = '0;
  logic                m_tvalid;
  logic                m_tready = 1'b0;
  logic [OUT_W-1:0]    m_tdata;

  // read word typed into the directed table, travels with the input word
  logic                row_typed = 1'b0;
  logic [PIN_W-1:0]    row_typed_rd = '0;

  // one directed row: the word to send and, where known at a glance, its read word
  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic [IDX_W-1:0] idx;
    logic [PIN_W-1:0] wdata;
    logic [PIN_W-1:0] pins;
    logic             typed;
    logic [PIN_W-1:0] typed_rd;
  } bus_row_t;

  // walk from reset through the modes of a pin: plain data, low level interrupts,
  // edge interrupts of both polarities, peripheral function
  bus_row_t directed_rows [DIRECTED_ROWS] = '{
    // register values right after reset
    '{CMD_READ,     IDX_MASK,     32'h0,          32'h0,          1'b1, 32'hFFFF_FFFF},
    '{CMD_READ,     IDX_FLAG,     32'h0,          32'h0,          1'b1, 32'h0},
    // pin offset returns this word's levels
    '{CMD_READ,     IDX_PINS,     32'hFFFF_FFFF,  32'hFFFF_FFFF,  1'b1, 32'hFFFF_FFFF},
    '{CMD_READ,     IDX_PINS,     32'h0,          32'h0,          1'b1, 32'h0},
    // unmapped and alias offsets read as zero
    '{CMD_READ,     IDX_TOP,      32'h0,          32'h0,          1'b1, 32'h0},
    '{CMD_READ,     IDX_DATA_SET, 32'h0,          32'h0,          1'b1, 32'h0},
    // writes to base and read-only offsets do nothing
    '{CMD_WRITE,    IDX_DATA,     32'hFFFF_FFFF,  32'h0,          1'b0, 32'h0},
    '{CMD_WRITE,    IDX_FLAG,     32'hFFFF_FFFF,  32'h0,          1'b0, 32'h0},
    '{CMD_WRITE,    IDX_TOP,      32'hFFFF_FFFF,  32'h0,          1'b0, 32'h0},
    // data set on pins outside interrupt mode sets data bits
    '{CMD_WRITE,    IDX_DATA_SET, 32'hFFFF_FFFF,  32'h0,          1'b0, 32'h0},
    '{CMD_READ,     IDX_DATA,     32'h0,          32'h0,          1'b1, 32'hFFFF_FFFF},
    '{CMD_WRITE,    IDX_DATA_CLR, 32'h0000_FFFF,  32'h0,          1'b0, 32'h0},
    // every pin to interrupt mode, low level, upper half low
    '{CMD_WRITE,    IDX_SEL_SET,  32'hFFFF_FFFF,  32'h0000_FFFF,  1'b0, 32'h0},
    '{CMD_WRITE,    IDX_MASK_CLR, 32'hFFFF_FFFF,  32'h0000_FFFF,  1'b0, 32'h0},
    '{CMD_READ,     IDX_FLAG,     32'h0,          32'hFFFF_FFFF,  1'b0, 32'h0},
    // data set on interrupt pins acks flags
    '{CMD_WRITE,    IDX_DATA_SET, 32'hFFFF_FFFF,  32'hFFFF_FFFF,  1'b0, 32'h0},
    // ack while the level still holds sets the flag again
    '{CMD_WRITE,    IDX_DATA_SET, 32'h0000_0001,  32'hFFFF_FFFE,  1'b0, 32'h0},
    // falling edges, then only the top pin pending
    '{CMD_WRITE,    IDX_TRIG_SET, 32'hFFFF_FFFF,  32'hFFFF_FFFE,  1'b0, 32'h0},
    '{CMD_WRITE,    IDX_DATA_SET, 32'hFFFF_FFFF,  32'hFFFF_FFFE,  1'b0, 32'h0},
    '{CMD_IDLE,     IDX_PINS,     32'h0,          32'h7FFF_FFFE,  1'b0, 32'h0},
    // rising polarity, top pin comes back up
    '{CMD_WRITE,    IDX_DIR_SET,  32'hFFFF_FFFF,  32'hFFFF_FFFF,  1'b0, 32'h0},
    '{CMD_WRITE,    IDX_MASK_SET, 32'h8000_0000,  32'hFFFF_FFFF,  1'b0, 32'h0},
    // peripheral function takes every pin
    '{CMD_WRITE,    IDX_FUNC_SET, 32'hFFFF_FFFF,  32'h0,          1'b0, 32'h0},
    '{CMD_WRITE,    IDX_PULL_SET, 32'hFFFF_FFFF,  32'h0,          1'b0, 32'h0},
    // command three is an idle tick even with a write offset
    '{CMD_IDLE_ALT, IDX_PULL_CLR, 32'hFFFF_FFFF,  32'hFFFF_FFFF,  1'b0, 32'h0},
    '{CMD_WRITE,    IDX_PULL_CLR, 32'hAAAA_AAAA,  32'h5555_5555,  1'b0, 32'h0},
    '{CMD_WRITE,    IDX_FUNC_CLR, 32'h0F0F_0F0F,  32'h0,          1'b0, 32'h0}
  };

  logic [IDX_W-1:0] read_offsets [9] = '{
    IDX_PINS, IDX_DATA, IDX_MASK, IDX_PULL, IDX_FUNC, IDX_SEL, IDX_DIR, IDX_TRIG, IDX_FLAG
  };

  logic [IDX_W-1:0] write_aliases [14] = '{
    IDX_DATA_SET, IDX_DATA_CLR, IDX_MASK_SET, IDX_MASK_CLR, IDX_PULL_SET, IDX_PULL_CLR,
    IDX_FUNC_SET, IDX_FUNC_CLR, IDX_SEL_SET, IDX_SEL_CLR, IDX_DIR_SET, IDX_DIR_CLR,
    IDX_TRIG_SET, IDX_TRIG_CLR
  };

  // predicted bank registers and the levels seen on the previous word
  bank_words_t      bank_regs;
  logic [PIN_W-1:0] last_pins;
  // results the bank still owes, oldest first
  result_t          bank_result_q [$];

  int  mismatch_count = 0;
  int  quiet_cycles = 0;
  bit  src_quiet = 1'b0;
  bit  sink_quiet = 1'b0;

  gpio_bank_with_pin_interrupts u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // step the bank by one word: read, then write, then pin detection
  function automatic result_t advance_bank(input logic [CMD_W-1:0] cmd,
                                           input logic [IDX_W-1:0] idx,
                                           input logic [PIN_W-1:0] wd,
                                           input logic [PIN_W-1:0] pins);
    result_t          res;
    logic [PIN_W-1:0] irq_pins;
    logic [PIN_W-1:0] edge_hit;
    logic [PIN_W-1:0] level_hit;
    res = '0;
    if (cmd == CMD_READ) begin
      case (idx)
        IDX_PINS: res.read_data = pins;
        IDX_DATA: res.read_data = bank_regs.data;
        IDX_MASK: res.read_data = bank_regs.mask;
        IDX_PULL: res.read_data = bank_regs.pull;
        IDX_FUNC: res.read_data = bank_regs.func;
        IDX_SEL:  res.read_data = bank_regs.sel;
        IDX_DIR:  res.read_data = bank_regs.dir;
        IDX_TRIG: res.read_data = bank_regs.trig;
        IDX_FLAG: res.read_data = bank_regs.flag;
        default:  res.read_data = '0;
      endcase
    end else if (cmd == CMD_WRITE) begin
      irq_pins = ~bank_regs.func & bank_regs.sel;
      case (idx)
        // ack on interrupt pins, data set everywhere else
        IDX_DATA_SET: begin
          bank_regs.flag &= ~(wd & irq_pins);
          bank_regs.data |= wd & ~irq_pins;
        end
        IDX_DATA_CLR: bank_regs.data &= ~wd;
        IDX_MASK_SET: bank_regs.mask |= wd;
        IDX_MASK_CLR: bank_regs.mask &= ~wd;
        IDX_PULL_SET: bank_regs.pull |= wd;
        IDX_PULL_CLR: bank_regs.pull &= ~wd;
        IDX_FUNC_SET: bank_regs.func |= wd;
        IDX_FUNC_CLR: bank_regs.func &= ~wd;
        IDX_SEL_SET:  bank_regs.sel |= wd;
        IDX_SEL_CLR:  bank_regs.sel &= ~wd;
        IDX_DIR_SET:  bank_regs.dir |= wd;
        IDX_DIR_CLR:  bank_regs.dir &= ~wd;
        IDX_TRIG_SET: bank_regs.trig |= wd;
        IDX_TRIG_CLR: bank_regs.trig &= ~wd;
        default: ;
      endcase
    end
    // detection runs on the configuration after the write
    irq_pins  = ~bank_regs.func & bank_regs.sel;
    edge_hit  = (bank_regs.dir & pins & ~last_pins) | (~bank_regs.dir & ~pins & last_pins);
    level_hit = ~(pins ^ bank_regs.dir);
    bank_regs.flag |= irq_pins & ((bank_regs.trig & edge_hit) | (~bank_regs.trig & level_hit));
    last_pins = pins;

    res.pin_out          = bank_regs.data;
    res.pin_drive_enable = bank_regs.dir & ~bank_regs.func & ~bank_regs.sel;
    res.pull_disabled    = bank_regs.pull;
    res.func_select      = bank_regs.func;
    res.alt_select       = bank_regs.sel;
    res.alt_high         = bank_regs.trig;
    res.irq_line         = |(bank_regs.flag & ~bank_regs.mask);
    res.pending_valid    = |bank_regs.flag;
    for (int i = PIN_W - 1; i >= 0; i--) begin
      if (bank_regs.flag[i]) res.pending_pin = PEND_W'(i);
    end
    return res;
  endfunction

  task automatic report_mismatch(input string what, input logic [PIN_W-1:0] got,
                                 input logic [PIN_W-1:0] want);
    mismatch_count++;
    if (mismatch_count <= PRINT_CAP)
      $display("%0t mismatch %s: got %h want %h", $realtime, what, got, want);
  endtask

  task automatic check_field(input string what, input logic [PIN_W-1:0] got,
                             input logic [PIN_W-1:0] want);
    if (got !== want) report_mismatch(what, got, want);
  endtask

  // predict every accepted input word, check every accepted result word
  always @(posedge clk) begin
    result_t got;
    result_t want;
    if (!rst) begin
      if (s_tvalid && s_tready) begin
        want = advance_bank(s_tuser, s_tdata[5:0], s_tdata[37:6], s_tdata[69:38]);
        if (row_typed) want.read_data = row_typed_rd;
        bank_result_q.push_back(want);
      end
      if (m_tvalid && m_tready) begin
        got = m_tdata;
        if (bank_result_q.size() == 0) begin
          report_mismatch("result word with none owed", got.read_data, '0);
        end else begin
          want = bank_result_q.pop_front();
          check_field("read_data", got.read_data, want.read_data);
          check_field("pin_out", got.pin_out, want.pin_out);
          check_field("pin_drive_enable", got.pin_drive_enable, want.pin_drive_enable);
          check_field("pull_disabled", got.pull_disabled, want.pull_disabled);
          check_field("func_select", got.func_select, want.func_select);
          check_field("alt_select", got.alt_select, want.alt_select);
          check_field("alt_high", got.alt_high, want.alt_high);
          check_field("irq_line", PIN_W'(got.irq_line), PIN_W'(want.irq_line));
          check_field("pending_valid", PIN_W'(got.pending_valid), PIN_W'(want.pending_valid));
          check_field("pending_pin", PIN_W'(got.pending_pin), PIN_W'(want.pending_pin));
        end
      end
      // watchdog on cycles where neither side moves a word
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
          $display("Verification failed");
          $finish;
        end
      end
    end
  end

  // drive one input word from a falling edge, return at the falling edge after it
  // is taken; valid is lowered only when a gap is drawn
  task automatic send_word(input logic [CMD_W-1:0] cmd, input logic [IDX_W-1:0] idx,
                           input logic [PIN_W-1:0] wd, input logic [PIN_W-1:0] pins,
                           input logic typed, input logic [PIN_W-1:0] typed_rd);
    int gap;
    gap = src_quiet ? 0 : $urandom_range(0, 8);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid     <= 1'b1;
    s_tuser      <= cmd;
    s_tdata      <= {2'b00, pins, wd, idx};
    row_typed    <= typed;
    row_typed_rd <= typed_rd;
    do @(posedge clk); while (!s_tready);
    @(negedge clk);
  endtask

  // result side: a random stall before every word, with stall-free stretches
  initial begin
    int stall;
    int taken;
    taken = 0;
    while (rst) @(negedge clk);
    forever begin
      if (taken % 64 == 0) sink_quiet = ($urandom_range(0, 2) == 0);
      stall = sink_quiet ? 0 : $urandom_range(0, 8);
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
      taken++;
      @(negedge clk);
    end
  end

  initial begin
    logic [CMD_W-1:0] cmd;
    logic [IDX_W-1:0] idx;
    logic [PIN_W-1:0] wd;
    logic [PIN_W-1:0] pins_now;
    int               pick;

    bank_regs      = '0;
    bank_regs.mask = '1;
    last_pins      = '0;
    pins_now       = '0;

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed table
    for (int r = 0; r < DIRECTED_ROWS; r++) begin
      send_word(directed_rows[r].cmd, directed_rows[r].idx, directed_rows[r].wdata,
                directed_rows[r].pins, directed_rows[r].typed, directed_rows[r].typed_rd);
      pins_now = directed_rows[r].pins;
    end

    // random part: mostly register traffic and pin wiggles, some unmapped noise
    for (int n = 0; n < RANDOM_WORDS; n++) begin
      if (n % 64 == 0) src_quiet = ($urandom_range(0, 2) == 0);
      pick = $urandom_range(0, 99);
      if (pick < 30) begin
        cmd = ($urandom_range(0, 4) == 0) ? CMD_IDLE_ALT : CMD_IDLE;
        idx = IDX_W'($urandom_range(0, 63));
      end else if (pick < 55) begin
        cmd = CMD_READ;
        idx = ($urandom_range(0, 6) == 0) ? IDX_W'($urandom_range(0, 63))
                                          : read_offsets[$urandom_range(0, 8)];
      end else begin
        cmd = CMD_WRITE;
        idx = ($urandom_range(0, 9) == 0) ? IDX_W'($urandom_range(0, 63))
                                          : write_aliases[$urandom_range(0, 13)];
      end
      case ($urandom_range(0, 3))
        0:       wd = $urandom;
        1:       wd = 32'h1 << $urandom_range(0, 31);
        2:       wd = $urandom & $urandom;
        default: wd = '1;
      endcase
      // pins mostly toggle a bit or a few so edges and levels come and go
      case ($urandom_range(0, 4))
        0, 1:    pins_now = pins_now ^ (32'h1 << $urandom_range(0, 31));
        2:       pins_now = pins_now ^ ($urandom & $urandom & $urandom);
        3:       pins_now = $urandom;
        default: ;
      endcase
      send_word(cmd, idx, wd, pins_now, 1'b0, '0);
    end
    s_tvalid  <= 1'b0;
    row_typed <= 1'b0;

    while (bank_result_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
